// ===== src/fep_pkg.sv =====
`timescale 1ns / 1ps

package fep_pkg;

    // Port field widths
    localparam int unsigned PORT_ADDR_W  = 12;
    localparam int unsigned PORT_VALUE_W = 5;
    localparam int unsigned SPREAD_W     = 2;

    // Item kinds
    localparam logic KIND_PROPAGATE = 1'b0;
    localparam logic KIND_READ      = 1'b1;

    // Largest horizontal spread; larger codes saturate to it
    localparam logic [SPREAD_W-1:0] SPREAD_MAX   = 2'd2;
    // Spread code that also decays the cell
    localparam logic [SPREAD_W-1:0] SPREAD_DECAY = 2'd1;

    // First row of every scan pass
    localparam int unsigned FIRST_ROW = 2;

endpackage

// ===== src/fep_if.sv =====
`timescale 1ns / 1ps

// Command channel: one propagate or read item
interface fep_cmd_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  kind;
    logic [fep_pkg::SPREAD_W-1:0]          spread;
    logic [fep_pkg::PORT_ADDR_W-1:0]       read_address;

    modport source (output valid, output kind, output spread, output read_address,
                    input ready);
    modport sink   (input valid, input kind, input spread, input read_address,
                    output ready);
endinterface

// Response channel: one result item per command item
interface fep_rsp_if;
    logic                                  valid;
    logic                                  ready;
    logic [fep_pkg::PORT_ADDR_W-1:0]       write_address;
    logic [fep_pkg::PORT_VALUE_W-1:0]      write_value;
    logic [fep_pkg::PORT_VALUE_W-1:0]      read_value;
    logic                                  frame_done;

    modport source (output valid, output write_address, output write_value,
                    output read_value, output frame_done, input ready);
    modport sink   (input valid, input write_address, input write_value,
                    input read_value, input frame_done, output ready);
endinterface

// ===== src/fep_buffer.sv =====
`timescale 1ns / 1ps

module fep_buffer #(
    parameter int unsigned DEPTH     = 4096,
    parameter int unsigned ADDR_W    = 12,
    parameter int unsigned CELL_W    = 5,
    parameter int unsigned HOT_BASE  = 4064,
    parameter int unsigned HOT_VALUE = 31
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [CELL_W-1:0] rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [CELL_W-1:0] wr_data,
    output logic              clear_busy
);

    logic [CELL_W-1:0] mem [DEPTH];
    logic [CELL_W-1:0] rd_data_reg;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic              clr_busy_reg;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [CELL_W-1:0] mem_wdata;
    logic [CELL_W-1:0] clr_value;

    // Bottom row starts hot, everything else cold
    assign clr_value = (clr_addr_reg >= ADDR_W'(HOT_BASE)) ? CELL_W'(HOT_VALUE) : '0;

    // Steer the single write port between clearing pass and updates
    assign mem_we    = clr_busy_reg || wr_en;
    assign mem_waddr = clr_busy_reg ? clr_addr_reg : wr_addr;
    assign mem_wdata = clr_busy_reg ? clr_value : wr_data;

    // Sweep the whole buffer once after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            clr_busy_reg <= 1'b1;
        end
        else if (clr_busy_reg)
        begin
            if (clr_addr_reg == ADDR_W'(DEPTH - 1))
            begin
                clr_busy_reg <= 1'b0;
            end
            clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
        end
    end

    // Storage: one write, one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data    = rd_data_reg;
    assign clear_busy = clr_busy_reg;

endmodule

// ===== src/fep_scan.sv =====
`timescale 1ns / 1ps

module fep_scan #(
    parameter int unsigned WIDTH  = 32,
    parameter int unsigned HEIGHT = 128,
    parameter int unsigned ADDR_W = 12
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    output logic [ADDR_W-1:0] src_addr,
    output logic              last
);

    localparam int unsigned COL_W = $clog2(WIDTH);
    localparam int unsigned ROW_W = $clog2(HEIGHT);
    localparam logic [ADDR_W-1:0] START_ADDR = ADDR_W'(fep_pkg::FIRST_ROW * WIDTH);

    logic [COL_W-1:0]  col_reg;
    logic [ROW_W-1:0]  row_reg;
    logic [ADDR_W-1:0] src_reg;
    logic              col_last;
    logic              row_last;

    assign col_last = (col_reg == COL_W'(WIDTH - 1));
    assign row_last = (row_reg == ROW_W'(HEIGHT - 1));

    // Walk down each column, then step to the next column
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= ROW_W'(fep_pkg::FIRST_ROW);
            src_reg <= START_ADDR;
        end
        else if (advance)
        begin
            if (!row_last)
            begin
                row_reg <= row_reg + ROW_W'(1);
                src_reg <= src_reg + ADDR_W'(WIDTH);
            end
            else
            begin
                row_reg <= ROW_W'(fep_pkg::FIRST_ROW);
                if (col_last)
                begin
                    col_reg <= '0;
                    src_reg <= START_ADDR;
                end
                else
                begin
                    col_reg <= col_reg + COL_W'(1);
                    src_reg <= START_ADDR + ADDR_W'(col_reg) + ADDR_W'(1);
                end
            end
        end
    end

    assign src_addr = src_reg;
    assign last     = col_last && row_last;

endmodule

// ===== src/fire_effect_propagator_unit.sv =====
`timescale 1ns / 1ps

// Fire effect propagator. Holds a BUFFER_WIDTH x BUFFER_HEIGHT intensity buffer
// in one synchronous memory and takes one item per clock cycle unless the result
// channel holds it back: a propagate item moves the next cell of the column-major
// scan one row up (with spread and decay), a read item returns one cell. Each item
// goes through the read stage, then the output register; the memory read of one
// item overlaps the write-back of the previous one, and a forwarding register
// covers the case where both touch the same cell. After reset the block clears
// every cell (bottom row to MAX_INTENSITY) and accepts no item until it is done.
module fire_effect_propagator_unit #(
    parameter int unsigned BUFFER_WIDTH  = 32,
    parameter int unsigned BUFFER_HEIGHT = 128,
    parameter int unsigned MAX_INTENSITY = 31
) (
    input  logic          clk,
    input  logic          rst_n,
    fep_cmd_if.sink       cmd,
    fep_rsp_if.source     rsp
);

    localparam int unsigned CELL_COUNT = BUFFER_WIDTH * BUFFER_HEIGHT;
    localparam int unsigned ADDR_W     = $clog2(CELL_COUNT);
    localparam int unsigned CELL_W     = $clog2(MAX_INTENSITY + 1);
    localparam int unsigned HOT_BASE   = (BUFFER_HEIGHT - 1) * BUFFER_WIDTH;
    localparam int unsigned PA_W       = fep_pkg::PORT_ADDR_W;
    localparam int unsigned PV_W       = fep_pkg::PORT_VALUE_W;

    // Buffer and scan
    logic              clear_busy;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [CELL_W-1:0] rd_data;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [CELL_W-1:0] wr_data;
    logic [ADDR_W-1:0] scan_src;
    logic              scan_last;

    // Read stage
    logic                          s2_valid_reg;
    logic                          s2_kind_reg;
    logic [fep_pkg::SPREAD_W-1:0]  s2_spread_reg;
    logic [ADDR_W-1:0]             s2_src_reg;
    logic                          s2_in_range_reg;
    logic                          s2_last_reg;
    logic                          fwd_hit_reg;
    logic [CELL_W-1:0]             fwd_data_reg;

    // Output register
    logic             out_valid_reg;
    logic [PA_W-1:0]  out_waddr_reg;
    logic [PV_W-1:0]  out_wvalue_reg;
    logic [PV_W-1:0]  out_rvalue_reg;
    logic             out_done_reg;

    logic                          accept;
    logic                          is_prop;
    logic                          s2_advance;
    logic [fep_pkg::SPREAD_W-1:0]  spread_sat;
    logic [ADDR_W+PA_W-1:0]        raddr_ext;
    logic                          in_range;
    logic [CELL_W-1:0]             src_value;
    logic                          cell_zero;
    logic [ADDR_W-1:0]             above;
    logic [ADDR_W-1:0]             dst;
    logic [CELL_W-1:0]             new_value;
    logic [ADDR_W+PA_W-1:0]        dst_ext;
    logic [CELL_W+PV_W-1:0]        value_ext;
    logic [CELL_W+PV_W-1:0]        cell_ext;

    fep_buffer #(
        .DEPTH     (CELL_COUNT),
        .ADDR_W    (ADDR_W),
        .CELL_W    (CELL_W),
        .HOT_BASE  (HOT_BASE),
        .HOT_VALUE (MAX_INTENSITY)
    ) u_buffer (
        .clk        (clk),
        .rst_n      (rst_n),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .clear_busy (clear_busy)
    );

    fep_scan #(
        .WIDTH  (BUFFER_WIDTH),
        .HEIGHT (BUFFER_HEIGHT),
        .ADDR_W (ADDR_W)
    ) u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (accept && is_prop),
        .src_addr (scan_src),
        .last     (scan_last)
    );

    // Accept after the clearing pass while the read stage is free or moving on
    assign s2_advance = !out_valid_reg || rsp.ready;
    assign cmd.ready  = !clear_busy && (!s2_valid_reg || s2_advance);
    assign accept     = cmd.valid && cmd.ready;
    assign is_prop    = (cmd.kind == fep_pkg::KIND_PROPAGATE);

    // Decode the incoming item
    assign spread_sat = (cmd.spread > fep_pkg::SPREAD_MAX) ? fep_pkg::SPREAD_MAX : cmd.spread;
    assign raddr_ext  = {{ADDR_W{1'b0}}, cmd.read_address};
    assign in_range   = ({20'b0, cmd.read_address} < 32'(CELL_COUNT));
    assign rd_en      = accept;
    assign rd_addr    = is_prop ? scan_src : raddr_ext[ADDR_W-1:0];

    // Update the cell read by the item in the read stage
    assign src_value = fwd_hit_reg ? fwd_data_reg : rd_data;
    assign cell_zero = (src_value == '0);
    assign above     = s2_src_reg - ADDR_W'(BUFFER_WIDTH);
    assign dst       = cell_zero ? above
                                 : above + ADDR_W'(s2_spread_reg) - ADDR_W'(1);
    assign new_value = (cell_zero || s2_spread_reg != fep_pkg::SPREAD_DECAY)
                       ? src_value : src_value - CELL_W'(1);

    assign wr_en   = s2_valid_reg && s2_advance && (s2_kind_reg == fep_pkg::KIND_PROPAGATE);
    assign wr_addr = dst;
    assign wr_data = new_value;

    assign dst_ext   = {{PA_W{1'b0}}, dst};
    assign value_ext = {{PV_W{1'b0}}, new_value};
    assign cell_ext  = {{PV_W{1'b0}}, src_value};

    // Read stage: hold item fields and catch a write to the cell being read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s2_valid_reg <= 1'b1;
        end
        else if (s2_advance)
        begin
            s2_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s2_kind_reg     <= cmd.kind;
            s2_spread_reg   <= spread_sat;
            s2_src_reg      <= scan_src;
            s2_in_range_reg <= in_range;
            s2_last_reg     <= scan_last;
            fwd_hit_reg     <= wr_en && (wr_addr == rd_addr);
            fwd_data_reg    <= new_value;
        end
    end

    // Output register: load the result, drop it when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s2_valid_reg && s2_advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg && s2_advance)
        begin
            if (s2_kind_reg == fep_pkg::KIND_PROPAGATE)
            begin
                out_waddr_reg  <= dst_ext[PA_W-1:0];
                out_wvalue_reg <= value_ext[PV_W-1:0];
                out_rvalue_reg <= '0;
                out_done_reg   <= s2_last_reg;
            end
            else
            begin
                out_waddr_reg  <= '0;
                out_wvalue_reg <= '0;
                out_rvalue_reg <= s2_in_range_reg ? cell_ext[PV_W-1:0] : '0;
                out_done_reg   <= 1'b0;
            end
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.write_address = out_waddr_reg;
    assign rsp.write_value   = out_wvalue_reg;
    assign rsp.read_value    = out_rvalue_reg;
    assign rsp.frame_done    = out_done_reg;

    // No update may collide with the clearing pass
    assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !clear_busy)
        else $error("buffer update during clearing pass");

    // A new result only appears after an item sat in the read stage
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp.valid) |-> $past(s2_valid_reg))
        else $error("result without a preceding item");

    // The last cell of a pass sends the scan back to its start
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_prop && scan_last)
            |=> (scan_src == ADDR_W'(fep_pkg::FIRST_ROW * BUFFER_WIDTH)))
        else $error("scan did not wrap after the last cell");

endmodule

// ===== tb/fire_effect_propagator_unit_test.sv =====
`timescale 1ns / 1ps

module fire_effect_propagator_unit_test;

    localparam int unsigned BUFFER_WIDTH   = 32;
    localparam int unsigned BUFFER_HEIGHT  = 128;
    localparam int unsigned MAX_INTENSITY  = 31;
    localparam int unsigned CELL_COUNT     = BUFFER_WIDTH * BUFFER_HEIGHT;
    localparam int unsigned BOTTOM_ROW     = (BUFFER_HEIGHT - 1) * BUFFER_WIDTH;

    // Spread codes that have no name in the package
    localparam logic [fep_pkg::SPREAD_W-1:0] SPREAD_LEFT    = 2'd0;
    localparam logic [fep_pkg::SPREAD_W-1:0] SPREAD_CLAMPED = 2'd3;

    localparam int DIRECTED_COUNT = 14;
    localparam int RANDOM_ITEMS   = 1936;
    localparam int TOTAL_ITEMS    = DIRECTED_COUNT + RANDOM_ITEMS;
    localparam int HOLD_AT        = 700;
    localparam int LONG_HOLD      = 300;
    localparam int PAUSE_AT       = 1300;
    localparam int QUIET_TAIL     = 150;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int REPORT_LIMIT   = 10;

    typedef struct packed {
        logic [fep_pkg::PORT_ADDR_W-1:0]  write_address;
        logic [fep_pkg::PORT_VALUE_W-1:0] write_value;
        logic [fep_pkg::PORT_VALUE_W-1:0] read_value;
        logic                             frame_done;
    } fire_result_t;

    typedef struct packed {
        logic                             kind;
        logic [fep_pkg::SPREAD_W-1:0]     spread;
        logic [fep_pkg::PORT_ADDR_W-1:0]  read_address;
        logic                             typed;
        fire_result_t                     result;
    } fire_step_t;

    logic clk = 1'b0;
    logic rst_n;

    fep_cmd_if cmd_ch ();
    fep_rsp_if rsp_ch ();

    fire_effect_propagator_unit #(
        .BUFFER_WIDTH  (BUFFER_WIDTH),
        .BUFFER_HEIGHT (BUFFER_HEIGHT),
        .MAX_INTENSITY (MAX_INTENSITY)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch)
    );

    // Shadow copy of the buffer and the scan position
    logic [fep_pkg::PORT_VALUE_W-1:0] heat_cells [CELL_COUNT];
    int unsigned                      scan_col;
    int unsigned                      scan_row;
    logic [fep_pkg::PORT_ADDR_W-1:0]  last_written;

    fire_result_t fire_results_due [$];

    int sent_count     = 0;
    int mismatch_count = 0;
    int propagate_seen = 0;
    int read_seen      = 0;
    int hot_writes     = 0;
    int passes_done    = 0;
    int idle_cycles    = 0;
    bit long_hold_done = 1'b0;

    // Directed items; typed results hold right after reset
    fire_step_t directed_steps [DIRECTED_COUNT] = '{
        '{fep_pkg::KIND_READ, SPREAD_LEFT, 12'd4064, 1'b1, '{12'd0, 5'd0, 5'd31, 1'b0}},
        '{fep_pkg::KIND_READ, SPREAD_LEFT, 12'd4095, 1'b1, '{12'd0, 5'd0, 5'd31, 1'b0}},
        '{fep_pkg::KIND_READ, SPREAD_LEFT, 12'd0,    1'b1, '{12'd0, 5'd0, 5'd0,  1'b0}},
        '{fep_pkg::KIND_READ, SPREAD_LEFT, 12'd4063, 1'b1, '{12'd0, 5'd0, 5'd0,  1'b0}},
        '{fep_pkg::KIND_PROPAGATE, SPREAD_LEFT, 12'd0, 1'b1, '{12'd32, 5'd0, 5'd0, 1'b0}},
        '{fep_pkg::KIND_PROPAGATE, fep_pkg::SPREAD_DECAY, 12'd4095, 1'b1,
          '{12'd64, 5'd0, 5'd0, 1'b0}},
        '{fep_pkg::KIND_PROPAGATE, fep_pkg::SPREAD_MAX, 12'd0, 1'b1,
          '{12'd96, 5'd0, 5'd0, 1'b0}},
        '{fep_pkg::KIND_PROPAGATE, SPREAD_CLAMPED, 12'hAAA, 1'b1,
          '{12'd128, 5'd0, 5'd0, 1'b0}},
        '{fep_pkg::KIND_READ, SPREAD_LEFT, 12'd32, 1'b0, '0},
        '{fep_pkg::KIND_READ, SPREAD_CLAMPED, 12'hAAA, 1'b0, '0},
        '{fep_pkg::KIND_READ, fep_pkg::SPREAD_DECAY, 12'h555, 1'b0, '0},
        '{fep_pkg::KIND_READ, fep_pkg::SPREAD_MAX, 12'hFFF, 1'b1,
          '{12'd0, 5'd0, 5'd31, 1'b0}},
        '{fep_pkg::KIND_PROPAGATE, SPREAD_LEFT, 12'h555, 1'b0, '0},
        '{fep_pkg::KIND_READ, SPREAD_LEFT, 12'd4065, 1'b0, '0}
    };

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 0;
    end

    // Work out the result of one item and update the shadow buffer
    function automatic fire_result_t predict_fire_step(
        input logic                            kind,
        input logic [fep_pkg::SPREAD_W-1:0]    spread,
        input logic [fep_pkg::PORT_ADDR_W-1:0] raddr);
        fire_result_t                     result;
        logic [fep_pkg::SPREAD_W-1:0]     drift;
        logic [fep_pkg::PORT_VALUE_W-1:0] heat;
        int unsigned                      src;
        int unsigned                      above;
        int unsigned                      dst;

        result = '0;
        if (kind == fep_pkg::KIND_READ)
        begin
            if (raddr < CELL_COUNT)
                result.read_value = heat_cells[raddr];
            return result;
        end

        drift = (spread > fep_pkg::SPREAD_MAX) ? fep_pkg::SPREAD_MAX : spread;
        src   = scan_row * BUFFER_WIDTH + scan_col;
        above = src - BUFFER_WIDTH;
        heat  = heat_cells[src];
        if (heat == 0)
        begin
            dst = above;
            result.write_value = '0;
        end
        else
        begin
            dst = above + drift - 1;
            result.write_value = (drift == fep_pkg::SPREAD_DECAY) ? heat - 1'b1 : heat;
        end
        heat_cells[dst]      = result.write_value;
        result.write_address = dst[fep_pkg::PORT_ADDR_W-1:0];
        last_written         = dst[fep_pkg::PORT_ADDR_W-1:0];

        // Advance the column-major scan
        if (scan_row + 1 < BUFFER_HEIGHT)
            scan_row = scan_row + 1;
        else
        begin
            scan_row = fep_pkg::FIRST_ROW;
            if (scan_col + 1 < BUFFER_WIDTH)
                scan_col = scan_col + 1;
            else
            begin
                scan_col = 0;
                result.frame_done = 1'b1;
            end
        end
        return result;
    endfunction

    // Offer one item, hold it until accepted, then queue its expected result
    task automatic offer_item(input logic kind, input logic [fep_pkg::SPREAD_W-1:0] spread,
                              input logic [fep_pkg::PORT_ADDR_W-1:0] raddr,
                              input logic typed, input fire_result_t typed_result);
        fire_result_t predicted;

        cmd_ch.valid        <= 1'b1;
        cmd_ch.kind         <= kind;
        cmd_ch.spread       <= spread;
        cmd_ch.read_address <= raddr;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        predicted = predict_fire_step(kind, spread, raddr);
        fire_results_due.push_back(typed ? typed_result : predicted);
        sent_count++;
        if (kind == fep_pkg::KIND_READ)
            read_seen++;
        else
            propagate_seen++;
    endtask

    task automatic report_mismatch(input string what, input fire_result_t due,
                                   input fire_result_t got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("%0t %s: expected wa=%0d wv=%0d rv=%0d fd=%0d got wa=%0d wv=%0d rv=%0d fd=%0d",
                     $realtime, what, due.write_address, due.write_value, due.read_value,
                     due.frame_done, got.write_address, got.write_value, got.read_value,
                     got.frame_done);
    endtask

    // Sender: reset, directed table, then random items
    initial
    begin
        logic                            kind_pick;
        logic [fep_pkg::SPREAD_W-1:0]    spread_pick;
        logic [fep_pkg::PORT_ADDR_W-1:0] addr_pick;
        int unsigned                     sel;

        rst_n               <= 1'b0;
        cmd_ch.valid        <= 1'b0;
        cmd_ch.kind         <= fep_pkg::KIND_PROPAGATE;
        cmd_ch.spread       <= SPREAD_LEFT;
        cmd_ch.read_address <= '0;
        for (int i = 0; i < CELL_COUNT; i++)
            heat_cells[i] = (i >= BOTTOM_ROW) ? fep_pkg::PORT_VALUE_W'(MAX_INTENSITY) : '0;
        scan_col     = 0;
        scan_row     = fep_pkg::FIRST_ROW;
        last_written = '0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_steps[i])
            offer_item(directed_steps[i].kind, directed_steps[i].spread,
                       directed_steps[i].read_address, directed_steps[i].typed,
                       directed_steps[i].result);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            sel         = $urandom_range(0, 99);
            kind_pick   = (sel < 65) ? fep_pkg::KIND_PROPAGATE : fep_pkg::KIND_READ;
            spread_pick = $urandom_range(0, 3);
            // Reads favor the cell just written, the scan front and the hot rows
            case ($urandom_range(0, 9))
                0, 1, 2, 3: addr_pick = last_written;
                4, 5, 6:    addr_pick = fep_pkg::PORT_ADDR_W'(scan_row * BUFFER_WIDTH
                                        + scan_col + $urandom_range(0, 66) - 33);
                7:          addr_pick = fep_pkg::PORT_ADDR_W'(BOTTOM_ROW - 3 * BUFFER_WIDTH
                                        + $urandom_range(0, 4 * BUFFER_WIDTH - 1));
                default:    addr_pick = $urandom_range(0, CELL_COUNT - 1);
            endcase
            offer_item(kind_pick, spread_pick, addr_pick, 1'b0, '0);

            // Pause once until the block has drained, otherwise idle in bursts
            if (n == PAUSE_AT)
            begin
                cmd_ch.valid <= 1'b0;
                do
                    @(posedge clk);
                while (fire_results_due.size() != 0);
            end
            else if (sent_count < TOTAL_ITEMS - QUIET_TAIL && $urandom_range(0, 3) == 0)
            begin
                cmd_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end

        // Wait for the last results, then let the pipeline settle
        cmd_ch.valid <= 1'b0;
        while (fire_results_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d propagate and %0d read items, %0d hot writes, %0d full passes.",
                 propagate_seen, read_seen, hot_writes, passes_done);
        $display("Receiver held off %0d cycles once; %0d mismatches.", LONG_HOLD, mismatch_count);
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Receiver: random ready bursts, one long hold-off, steady ready at the tail
    initial
    begin
        rsp_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (!long_hold_done && sent_count >= HOLD_AT)
            begin
                long_hold_done = 1'b1;
                rsp_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if (sent_count >= TOTAL_ITEMS - QUIET_TAIL || $urandom_range(0, 2) != 0)
            begin
                rsp_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
            else
            begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin
        fire_result_t due;
        fire_result_t got;

        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            got.write_address = rsp_ch.write_address;
            got.write_value   = rsp_ch.write_value;
            got.read_value    = rsp_ch.read_value;
            got.frame_done    = rsp_ch.frame_done;
            if (fire_results_due.size() == 0)
                report_mismatch("unexpected result", '0, got);
            else
            begin
                due = fire_results_due.pop_front();
                if (got.write_address !== due.write_address
                    || got.write_value !== due.write_value
                    || got.read_value !== due.read_value
                    || got.frame_done !== due.frame_done)
                    report_mismatch("result mismatch", due, got);
                if (got.write_value != 0)
                    hot_writes++;
                if (got.frame_done)
                    passes_done++;
            end
        end
    end

    // Watchdog: count cycles in which neither channel moves an item
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Timeout after %0d idle cycles, %0d results outstanding",
                         idle_cycles, fire_results_due.size());
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

endmodule

// ===== sim.f =====
src/fep_pkg.sv
src/fep_if.sv
src/fep_buffer.sv
src/fep_scan.sv
src/fire_effect_propagator_unit.sv
tb/fire_effect_propagator_unit_test.sv
